// File: sv/gmcc_pkg.sv
// Shared types, codes and constants for the glyph margin crop checker.
// No dependencies; every other file imports this package.
package gmcc_pkg;

    localparam int GMCC_MAX_SIDE   = 256;
    localparam int GMCC_MIN_SIDE   = 6;
    localparam int GMCC_RESET_SIDE = 184;
    localparam int GMCC_CFG_W      = 9;
    localparam int GMCC_EDGE_W     = 8;
    localparam int GMCC_PIXEL_W    = 32;
    localparam int GMCC_OUT_W      = 40;

    // Side indexes into the class array
    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    // Per-side class: second ring lit, else third ring lit, else clear
    typedef enum logic [1:0] {
        CLS_SECOND = 2'd0,
        CLS_THIRD  = 2'd1,
        CLS_CLEAR  = 2'd2
    } side_class_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BORDER = 2'd1,
        ST_VERT   = 2'd2,
        ST_HORZ   = 2'd3
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [GMCC_EDGE_W-1:0] left_edge;
        logic [GMCC_EDGE_W-1:0] top_edge;
        logic [GMCC_EDGE_W-1:0] right_edge;
        logic [GMCC_EDGE_W-1:0] bottom_edge;
    } gmcc_result_t;

    function automatic side_class_t mark_class(side_class_t cur, logic at_second,
                                               logic at_third);
        side_class_t res;
        res = cur;
        if (at_second) begin
            res = CLS_SECOND;
        end else if (at_third && (cur == CLS_CLEAR)) begin
            res = CLS_THIRD;
        end
        return res;
    endfunction

endpackage

// File: sv/gmcc_scan.sv
// Raster position counters, border flag and per-side ring classes, plus the
// end-of-image crop decision. Depends on gmcc_pkg.
module gmcc_scan #(
    parameter int MAX_SIDE = gmcc_pkg::GMCC_MAX_SIDE
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         restart,
    input  logic                         step,
    input  logic                         lit,
    input  logic [$clog2(MAX_SIDE):0]    side,
    output logic                         is_last,
    output gmcc_pkg::gmcc_result_t       result
);
    import gmcc_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = CW + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic          border_reg, border_next;
    side_class_t   cls_reg [4];
    side_class_t   cls_next [4];

    logic [SW-1:0]             side_m1_w, side_m2_w, side_m3_w;
    logic [CW-1:0]             side_m1, side_m2, side_m3;
    logic [SW+GMCC_EDGE_W-1:0] far_ext;
    logic                      last_col;
    side_class_t               ct, cb, cl, cr;
    status_t                   status;
    logic [GMCC_EDGE_W-1:0]    left_v, top_v;

    always_comb begin
        side_m1_w = side - SW'(1);
        side_m2_w = side - SW'(2);
        side_m3_w = side - SW'(3);
        side_m1   = side_m1_w[CW-1:0];
        side_m2   = side_m2_w[CW-1:0];
        side_m3   = side_m3_w[CW-1:0];
        far_ext   = {{GMCC_EDGE_W{1'b0}}, side_m3_w};

        last_col = (col_reg == side_m1);
        is_last  = last_col && (row_reg == side_m1);
        col_next = last_col ? '0 : col_reg + CW'(1);
        row_next = last_col ? row_reg + CW'(1) : row_reg;

        border_next = border_reg;
        for (int k = 0; k < 4; k++) begin
            cls_next[k] = cls_reg[k];
        end
        if (lit) begin
            if ((row_reg == '0) || (row_reg == side_m1) ||
                (col_reg == '0) || (col_reg == side_m1)) begin
                border_next = 1'b1;
            end
            cls_next[SIDE_TOP]    = mark_class(cls_reg[SIDE_TOP],
                                               row_reg == CW'(1), row_reg == CW'(2));
            cls_next[SIDE_BOTTOM] = mark_class(cls_reg[SIDE_BOTTOM],
                                               row_reg == side_m2, row_reg == side_m3);
            cls_next[SIDE_LEFT]   = mark_class(cls_reg[SIDE_LEFT],
                                               col_reg == CW'(1), col_reg == CW'(2));
            cls_next[SIDE_RIGHT]  = mark_class(cls_reg[SIDE_RIGHT],
                                               col_reg == side_m2, col_reg == side_m3);
        end

        // Crop decision on the classes including the current pixel
        ct = cls_next[SIDE_TOP];
        cb = cls_next[SIDE_BOTTOM];
        cl = cls_next[SIDE_LEFT];
        cr = cls_next[SIDE_RIGHT];
        status = ST_OK;
        left_v = GMCC_EDGE_W'(2);
        top_v  = GMCC_EDGE_W'(2);
        if (border_next) begin
            status = ST_BORDER;
        end else begin
            if (ct == CLS_SECOND) begin
                if (cb != CLS_CLEAR) status = ST_VERT;
                else                 top_v = GMCC_EDGE_W'(3);
            end else if (cb == CLS_SECOND) begin
                if (ct != CLS_CLEAR) status = ST_VERT;
                else                 top_v = GMCC_EDGE_W'(1);
            end
            if (status == ST_OK) begin
                if (cl == CLS_SECOND) begin
                    if (cr != CLS_CLEAR) status = ST_HORZ;
                    else                 left_v = GMCC_EDGE_W'(3);
                end else if (cr == CLS_SECOND) begin
                    if (cl != CLS_CLEAR) status = ST_HORZ;
                    else                 left_v = GMCC_EDGE_W'(1);
                end
            end
        end
        if (status != ST_OK) begin
            left_v = '0;
            top_v  = '0;
        end

        result.status      = status;
        result.left_edge   = left_v;
        result.top_edge    = top_v;
        result.right_edge  = far_ext[GMCC_EDGE_W-1:0];
        result.bottom_edge = far_ext[GMCC_EDGE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart || (step && is_last)) begin
            col_reg    <= '0;
            row_reg    <= '0;
            border_reg <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                cls_reg[k] <= CLS_CLEAR;
            end
        end else if (step) begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            border_reg <= border_next;
            for (int k = 0; k < 4; k++) begin
                cls_reg[k] <= cls_next[k];
            end
        end
    end

endmodule

// File: sv/gmcc_result_stage.sv
// Output register for the crop result beat, with its stream handshake.
// Depends on gmcc_pkg.
module gmcc_result_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  gmcc_pkg::gmcc_result_t              result_in,
    output logic                                busy,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gmcc_pkg::GMCC_OUT_W-1:0]     m_tdata
);
    import gmcc_pkg::*;

    localparam int PAD_W = GMCC_OUT_W - 2 - 4 * GMCC_EDGE_W;

    logic         valid_reg;
    gmcc_result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

    assign busy     = valid_reg && !m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, data_reg.bottom_edge, data_reg.right_edge,
                       data_reg.top_edge, data_reg.left_edge, data_reg.status};

endmodule

// File: sv/glyph_margin_crop_checker.sv
// Top level of the glyph margin crop checker: input register, side register,
// scan logic and result stage. Depends on gmcc_pkg, gmcc_scan, gmcc_result_stage.
//
//  Channel   Direction  Beat contents (lowest bit first)
//  s_        in         pixel[31:0], one pixel per beat in raster order
//  m_        out        status[1:0] left[9:2] top[17:10] right[25:18]
//                       bottom[33:26], zero pad [39:34]; one beat per image
//  cfg_      in         image_side[8:0], written while idle
//
//  Cycles: one pixel per clock sustained unless a held result stops the last
//  pixel; the loop that sets it is the single counter/class update in gmcc_scan.
//  Output: the last pixel beat passes the input register, then its result is
//  loaded into the result stage register, which drives m_tvalid.
//  Reset: synchronous on aresetn low; clears counters, classes and both valids.
//  Stalls: a held result only stops the last pixel of the next image; all
//  earlier pixels keep flowing while the result waits.
module glyph_margin_crop_checker #(
    parameter int MAX_SIDE = gmcc_pkg::GMCC_MAX_SIDE
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration: image_side
    input  logic                                  cfg_we,
    input  logic [gmcc_pkg::GMCC_CFG_W-1:0]       cfg_wdata,
    // Pixel stream; tdata: pixel[31:0]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [gmcc_pkg::GMCC_PIXEL_W-1:0]     s_tdata,
    // Result stream; tdata: status[1:0], left_edge[9:2], top_edge[17:10],
    // right_edge[25:18], bottom_edge[33:26], zeros[39:34]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gmcc_pkg::GMCC_OUT_W-1:0]       m_tdata
);
    import gmcc_pkg::*;

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = CW + 1;
    localparam int EW = (SW > GMCC_CFG_W) ? SW : GMCC_CFG_W;
    localparam int RESET_SIDE = (GMCC_RESET_SIDE > MAX_SIDE) ? MAX_SIDE : GMCC_RESET_SIDE;

    logic [SW-1:0] side_reg, side_next;
    logic [EW-1:0] cfg_ext;
    logic          in_valid_reg, in_valid_next;
    logic          lit_reg;
    logic          advance;
    logic          is_last;
    logic          out_busy;
    gmcc_result_t  result;

    // Clamp the written side into the supported range
    always_comb begin
        cfg_ext = EW'(cfg_wdata);
        if (cfg_ext < EW'(GMCC_MIN_SIDE)) begin
            side_next = SW'(GMCC_MIN_SIDE);
        end else if (cfg_ext > EW'(MAX_SIDE)) begin
            side_next = SW'(MAX_SIDE);
        end else begin
            side_next = SW'(cfg_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SW'(RESET_SIDE);
        end else if (cfg_we) begin
            side_reg <= side_next;
        end
    end

    // Hold the pixel beat until the scan takes it; the last pixel waits
    // only if the previous result is still unaccepted.
    assign advance  = in_valid_reg && !(is_last && out_busy);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Only the lit flag is needed downstream
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            lit_reg <= |s_tdata;
        end
    end

    gmcc_scan #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_we),
        .step    (advance),
        .lit     (lit_reg),
        .side    (side_reg),
        .is_last (is_last),
        .result  (result)
    );

    gmcc_result_stage u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && is_last),
        .result_in (result),
        .busy      (out_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: sv/gmcc_checker.sv
// Port-level checks on the crop checker's result stream, and the bind that
// attaches them to the top level. Depends on gmcc_pkg and the top level.
module gmcc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gmcc_pkg::GMCC_OUT_W-1:0]   m_tdata
);
    import gmcc_pkg::*;

    // A stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Errors carry zero left and top edges
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != ST_OK) |-> (m_tdata[17:2] == 16'd0))
        else $error("error result with nonzero crop edges");

    // A good crop moves each near edge by at most one from two
    a_ok_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_OK) |->
            ((m_tdata[9:2] == 8'd1) || (m_tdata[9:2] == 8'd2) || (m_tdata[9:2] == 8'd3)) &&
            ((m_tdata[17:10] == 8'd1) || (m_tdata[17:10] == 8'd2) ||
             (m_tdata[17:10] == 8'd3)))
        else $error("good crop with near edge out of range");

    // Far edges always agree
    a_far: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:18] == m_tdata[33:26]))
        else $error("right and bottom edges differ");

    // No result beat straight after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind glyph_margin_crop_checker gmcc_checker u_gmcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
